[src/tle_pkg.sv]
// Package for the telnet line input editor: field widths, request codes,
// result kinds, telnet byte values and the controller/datapath structs.
// No dependencies.
package tle_pkg;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 6;
  localparam int PHASE_W = 2;
  localparam int FIX_MAX = 4;
  localparam int FIXN_W  = 3;

  // Input request codes.
  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_PW_ON   = 2'd1;
  localparam logic [OP_W-1:0] OP_PW_OFF  = 2'd2;
  localparam logic [OP_W-1:0] OP_PROMPT  = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DISC  = 3'd4;

  // Receive phases of the IAC parser.
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd0;
  localparam logic [PHASE_W-1:0] PH_IAC  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DO   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONT = 2'd3;

  // Byte values.
  localparam logic [BYTE_W-1:0] B_BS        = 8'd8;
  localparam logic [BYTE_W-1:0] B_LF        = 8'd10;
  localparam logic [BYTE_W-1:0] B_CR        = 8'd13;
  localparam logic [BYTE_W-1:0] B_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] B_TILDE     = 8'd126;
  localparam logic [BYTE_W-1:0] B_DEL       = 8'd127;
  localparam logic [BYTE_W-1:0] B_ZERO      = 8'd0;
  localparam logic [BYTE_W-1:0] OPT_ECHO    = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_EOR     = 8'd25;
  localparam logic [BYTE_W-1:0] CMD_EOR     = 8'd239;
  localparam logic [BYTE_W-1:0] CMD_IP      = 8'd244;
  localparam logic [BYTE_W-1:0] CMD_EC      = 8'd247;
  localparam logic [BYTE_W-1:0] CMD_EL      = 8'd248;
  localparam logic [BYTE_W-1:0] CMD_GA      = 8'd249;
  localparam logic [BYTE_W-1:0] CMD_WILL    = 8'd251;
  localparam logic [BYTE_W-1:0] CMD_WONT    = 8'd252;
  localparam logic [BYTE_W-1:0] CMD_DO      = 8'd253;
  localparam logic [BYTE_W-1:0] CMD_DONT    = 8'd254;
  localparam logic [BYTE_W-1:0] CMD_IAC     = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input request and latch its plan
    logic idx_inc;    // advance the result index
    logic rd_en;      // read the line store at the result index
    logic emit_fix;   // load the next fixed result into the output register
    logic emit_char;  // load the line character just read
    logic emit_end;   // load the line-end result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dec_line;   // the request on the input ends a line
    logic dec_fix;    // the request on the input gives fixed results
    logic fix_last;   // the current fixed result is the final one
    logic rd_done;    // every character of the line has been read out
    logic out_free;   // the output register can take a result this cycle
  } sts_t;

endpackage

[src/telnet_line_input_editor.sv]
// Telnet line input editor, top level: stream ports, controller and datapath.
// Depends on tle_pkg, tle_ctrl, tle_dp and tle_ram.
// An echo, reply or disconnect is loaded into the output register from the fixed-result state,
// a line's characters each by a store read and then a load. Replies leave at one per cycle
// while the output register is free; the line end takes a count check and then a load.
// Reset (rst_ni, asynchronous, active low) clears control and editor state, not the store.
module telnet_line_input_editor #(
  parameter int LINE_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input requests.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  // Results.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [13:8] line_length, [15:14] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o,   // final result of the request
  // Configuration write: ga_preferred.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  import tle_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [BYTE_W-1:0] out_data;
  logic [CNT_W-1:0]  out_len;

  // The preference register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller takes a request only when the previous one has put all of
  // its results into the output register; the register itself decouples the
  // downstream side, so a new request may be taken while a result waits.
  // A request with no result leaves the controller idle, so the next one can
  // be taken in the following cycle.
  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath decodes the request, updates the editor state and builds
  // each result from the latched plan or from the line store.
  tle_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (s_axis_tuser_i),
    .rx_byte_i    (s_axis_tdata_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tready_i (m_axis_tready_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_kind_o   (m_axis_tuser_o),
    .out_data_o   (out_data),
    .out_len_o    (out_len),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the payload with the byte lowest and zero padding on top.
  assign m_axis_tdata_o = {2'b00, out_len, out_data};

endmodule

[src/tle_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/tle_ctrl.sv]
// Controller of the telnet line input editor: sequences the results of
// one request. Depends on tle_pkg.
module tle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  tle_pkg::sts_t sts_i,
  output tle_pkg::cmd_t cmd_o
);

  import tle_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIX  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  logic [2:0] state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.dec_line) begin
            state_d = ST_RD;
          end else if (sts_i.dec_fix) begin
            state_d = ST_FIX;
          end
        end
      end
      ST_FIX: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fix = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          if (sts_i.fix_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        if (sts_i.rd_done) begin
          state_d = ST_END;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_RDW;
        end
      end
      ST_RDW: begin
        if (sts_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = ST_RD;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/tle_dp.sv]
// Datapath of the telnet line input editor: request decode, editor state,
// line store, result index and output register. Depends on tle_pkg, tle_ram.
module tle_dp #(
  parameter int LINE_MAX = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tle_pkg::OP_W-1:0]     op_i,
  input  logic [tle_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_data_i,
  input  tle_pkg::cmd_t                cmd_i,
  output tle_pkg::sts_t                sts_o,
  input  logic                         out_tready_i,
  output logic                         out_tvalid_o,
  output logic [tle_pkg::KIND_W-1:0]   out_kind_o,
  output logic [tle_pkg::BYTE_W-1:0]   out_data_o,
  output logic [tle_pkg::CNT_W-1:0]    out_len_o,
  output logic                         out_last_o
);

  import tle_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_MAX - 3);

  // Editor state.
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic cr_q, cr_d, lf_q, lf_d;
  logic echo_q, echo_d, pw_q, pw_d, eor_q, eor_d, ga_q, ga_d;
  logic ga_pref_q;

  // Plan of the request being read out.
  logic [FIX_MAX-1:0][BYTE_W-1:0] fix_q, fix_d;
  logic [FIXN_W-1:0]              fix_n_q, fix_n_d;
  logic [KIND_W-1:0]              fix_kind_q, fix_kind_d;
  logic [CNT_W-1:0]               len_q;
  logic [CNT_W-1:0]               idx_q;
  logic                           line_end, we;

  // Output register.
  logic              ov_q;
  logic [KIND_W-1:0] okind_q;
  logic [BYTE_W-1:0] odata_q;
  logic [CNT_W-1:0]  olen_q;
  logic              olast_q;

  logic [BYTE_W-1:0] rd_data;

  always_comb begin
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    cr_d       = cr_q;
    lf_d       = lf_q;
    echo_d     = echo_q;
    pw_d       = pw_q;
    eor_d      = eor_q;
    ga_d       = ga_q;
    fix_d      = '0;
    fix_n_d    = '0;
    fix_kind_d = KIND_REPLY;
    line_end   = 1'b0;
    we         = 1'b0;
    case (op_i)
      OP_BYTE: begin
        case (phase_q)
          PH_DATA: begin
            if (rx_byte_i == CMD_IAC) begin
              cr_d    = 1'b0;
              lf_d    = 1'b0;
              phase_d = PH_IAC;
            end else if (rx_byte_i == B_LF) begin
              if (cr_q) begin
                cr_d = 1'b0;
                lf_d = 1'b0;
              end else begin
                lf_d     = 1'b1;
                line_end = 1'b1;
              end
            end else if (rx_byte_i == B_CR) begin
              if (lf_q) begin
                cr_d = 1'b0;
                lf_d = 1'b0;
              end else begin
                cr_d     = 1'b1;
                line_end = 1'b1;
              end
            end else begin
              cr_d = 1'b0;
              lf_d = 1'b0;
              if (rx_byte_i == B_BS || rx_byte_i == B_DEL || rx_byte_i == CMD_EC) begin
                if (cnt_q != '0) begin
                  cnt_d = cnt_q - 1'b1;
                end
              end else if (rx_byte_i >= B_SPACE && rx_byte_i <= B_TILDE && cnt_q < FULL) begin
                we    = 1'b1;
                cnt_d = cnt_q + 1'b1;
                if (!pw_q && echo_q) begin
                  fix_n_d    = FIXN_W'(1);
                  fix_d[0]   = rx_byte_i;
                  fix_kind_d = KIND_ECHO;
                end
              end
            end
            if (line_end) begin
              cnt_d = '0;
            end
          end
          PH_IAC: begin
            phase_d = PH_DATA;
            if (rx_byte_i == CMD_EC) begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end else if (rx_byte_i == CMD_EL) begin
              cnt_d = '0;
            end else if (rx_byte_i == CMD_IP) begin
              fix_n_d    = FIXN_W'(1);
              fix_kind_d = KIND_DISC;
            end else if (rx_byte_i == CMD_DO) begin
              phase_d = PH_DO;
            end else if (rx_byte_i == CMD_DONT) begin
              phase_d = PH_DONT;
            end
          end
          PH_DO: begin
            phase_d = PH_DATA;
            if (rx_byte_i == OPT_ECHO) begin
              if (!pw_q) begin
                echo_d = 1'b1;
              end
            end else if (rx_byte_i == OPT_EOR) begin
              eor_d    = 1'b1;
              ga_d     = 1'b0;
              fix_n_d  = FIXN_W'(2);
              fix_d[0] = CMD_IAC;
              fix_d[1] = OPT_EOR;
            end
          end
          default: begin
            phase_d = PH_DATA;
            if (rx_byte_i == OPT_ECHO) begin
              echo_d = 1'b0;
            end else if (rx_byte_i == OPT_EOR) begin
              eor_d = 1'b0;
              if (ga_pref_q) begin
                ga_d = 1'b1;
              end
            end
          end
        endcase
      end
      OP_PW_ON, OP_PW_OFF: begin
        pw_d = (op_i == OP_PW_ON);
        if (!echo_q) begin
          fix_n_d  = FIXN_W'(3);
          fix_d[0] = CMD_IAC;
          fix_d[1] = (op_i == OP_PW_ON) ? CMD_WILL : CMD_WONT;
          fix_d[2] = OPT_ECHO;
        end
      end
      default: begin
        case ({ga_q, eor_q})
          2'b11: begin
            fix_n_d  = FIXN_W'(4);
            fix_d[0] = CMD_IAC;
            fix_d[1] = CMD_GA;
            fix_d[2] = CMD_IAC;
            fix_d[3] = CMD_EOR;
          end
          2'b10: begin
            fix_n_d  = FIXN_W'(2);
            fix_d[0] = CMD_IAC;
            fix_d[1] = CMD_GA;
          end
          2'b01: begin
            fix_n_d  = FIXN_W'(2);
            fix_d[0] = CMD_IAC;
            fix_d[1] = CMD_EOR;
          end
          default: begin
            fix_n_d = '0;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      phase_q   <= PH_DATA;
      cr_q      <= 1'b0;
      lf_q      <= 1'b0;
      echo_q    <= 1'b0;
      pw_q      <= 1'b0;
      eor_q     <= 1'b0;
      ga_q      <= 1'b0;
      ga_pref_q <= 1'b0;
      idx_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ga_pref_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        cr_q    <= cr_d;
        lf_q    <= lf_d;
        echo_q  <= echo_d;
        pw_q    <= pw_d;
        eor_q   <= eor_d;
        ga_q    <= ga_d;
        idx_q   <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit_fix || cmd_i.emit_char || cmd_i.emit_end) begin
        ov_q <= 1'b1;
      end else if (out_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Plan and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fix_q      <= fix_d;
      fix_n_q    <= fix_n_d;
      fix_kind_q <= fix_kind_d;
      len_q      <= cnt_q;
    end
    if (cmd_i.emit_fix) begin
      okind_q <= fix_kind_q;
      odata_q <= fix_q[idx_q[1:0]];
      olen_q  <= '0;
      olast_q <= sts_o.fix_last;
    end else if (cmd_i.emit_char) begin
      okind_q <= KIND_CHAR;
      odata_q <= rd_data;
      olen_q  <= '0;
      olast_q <= 1'b0;
    end else if (cmd_i.emit_end) begin
      okind_q <= KIND_END;
      odata_q <= B_ZERO;
      olen_q  <= len_q;
      olast_q <= 1'b1;
    end
  end

  tle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign sts_o.dec_line = line_end;
  assign sts_o.dec_fix  = (fix_n_d != '0);
  assign sts_o.fix_last = (idx_q[FIXN_W-1:0] == FIXN_W'(fix_n_q - 1'b1));
  assign sts_o.rd_done  = (idx_q == len_q);
  assign sts_o.out_free = !ov_q || out_tready_i;

  assign out_tvalid_o = ov_q;
  assign out_kind_o   = okind_q;
  assign out_data_o   = odata_q;
  assign out_len_o    = olen_q;
  assign out_last_o   = olast_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the telnet line input editor: a behavioural
// predictor of the editor, a stream driver with random gaps, a stalling receiver
// and a result checker. Depends on tle_pkg and telnet_line_input_editor.
module testbench;
  import tle_pkg::*;

  localparam int LINE_MAX    = 64;
  localparam int LINE_KEEP   = LINE_MAX - 3;   // most characters a line may hold
  localparam int HALF_PERIOD = 6;
  localparam int RESET_LEN   = 8;
  // Cycles without any handshake before the run is declared hung. The longest
  // quiet stretch in a correct run is the deliberate receiver hold-off below.
  localparam int HANG_LIMIT  = 2000;
  localparam int HOLD_OFF    = 300;
  // A request with no result leaves the block idle again; this is ample.
  localparam int SETTLE      = 8;
  // A full line read-out reads and loads each character, then the line end.
  localparam int DRAIN       = 2 * LINE_MAX + 16;
  // Telnet option code for suppress-go-ahead, which the editor does not handle.
  localparam logic [BYTE_W-1:0] OPT_SGA = 8'd3;

  // One result as the editor should present it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  len;
    logic              last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;    // [7:0] rx_byte
  logic [1:0]  s_axis_tuser_i;    // [1:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;    // [7:0] data_byte, [13:8] line_length, [15:14] zero
  logic [2:0]  m_axis_tuser_o;    // [2:0] kind
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  telnet_line_input_editor #(
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Predicted editor state, kept in step with every accepted request.
  logic [BYTE_W-1:0]  ed_store [LINE_MAX];
  int                 ed_count;
  logic [PHASE_W-1:0] ed_phase;
  logic               ed_after_cr;
  logic               ed_after_lf;
  logic               ed_echo;
  logic               ed_password;
  logic               ed_eor;
  logic               ed_ga;
  logic               ed_ga_pref;

  // Results of the request being predicted, and every result still awaited.
  result_t step_out[$];
  result_t awaited_results[$];
  result_t seen_want;

  int   fault_count  = 0;
  int   quiet_cycles = 0;
  int   hold_request = 0;   // set by a test to make the receiver hold off
  logic src_idle;           // random gaps between requests
  logic sink_idle;          // random receiver stalls

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_result(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] data,
                                     input logic [CNT_W-1:0]  len);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.len  = len;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // A finished line leaves as its characters in order, then the line end.
  function automatic void flush_line();
    int i;
    for (i = 0; i < ed_count; i++) add_result(KIND_CHAR, ed_store[i], '0);
    add_result(KIND_END, B_ZERO, CNT_W'(ed_count));
    ed_count = 0;
  endfunction

  // Works out the results of one accepted request and queues them.
  task automatic predict_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] c);
    step_out.delete();
    case (op)
      OP_BYTE: begin
        case (ed_phase)
          PH_DATA: begin
            if (c == CMD_IAC) begin
              ed_after_cr = 1'b0;
              ed_after_lf = 1'b0;
              ed_phase    = PH_IAC;
            end else if (c == B_LF) begin
              // An LF straight after a CR only completes the pair.
              if (ed_after_cr) begin
                ed_after_cr = 1'b0;
                ed_after_lf = 1'b0;
              end else begin
                ed_after_lf = 1'b1;
                flush_line();
              end
            end else if (c == B_CR) begin
              if (ed_after_lf) begin
                ed_after_cr = 1'b0;
                ed_after_lf = 1'b0;
              end else begin
                ed_after_cr = 1'b1;
                flush_line();
              end
            end else begin
              ed_after_cr = 1'b0;
              ed_after_lf = 1'b0;
              if (c == B_BS || c == B_DEL || c == CMD_EC) begin
                if (ed_count != 0) ed_count--;
              end else if (c >= B_SPACE && c <= B_TILDE && ed_count < LINE_KEEP) begin
                ed_store[ed_count] = c;
                ed_count++;
                if (!ed_password && ed_echo) add_result(KIND_ECHO, c, '0);
              end
            end
          end
          PH_IAC: begin
            ed_phase = PH_DATA;
            case (c)
              CMD_EC: begin
                if (ed_count != 0) ed_count--;
              end
              CMD_EL:  ed_count = 0;
              CMD_IP:  add_result(KIND_DISC, B_ZERO, '0);
              CMD_DO:  ed_phase = PH_DO;
              CMD_DONT: ed_phase = PH_DONT;
              default: ;
            endcase
          end
          PH_DO: begin
            ed_phase = PH_DATA;
            if (c == OPT_ECHO) begin
              if (!ed_password) ed_echo = 1'b1;
            end else if (c == OPT_EOR) begin
              ed_eor = 1'b1;
              ed_ga  = 1'b0;
              add_result(KIND_REPLY, CMD_IAC, '0);
              add_result(KIND_REPLY, OPT_EOR, '0);
            end
          end
          default: begin
            ed_phase = PH_DATA;
            if (c == OPT_ECHO) begin
              ed_echo = 1'b0;
            end else if (c == OPT_EOR) begin
              ed_eor = 1'b0;
              if (ed_ga_pref) ed_ga = 1'b1;
            end
          end
        endcase
      end
      OP_PW_ON: begin
        ed_password = 1'b1;
        if (!ed_echo) begin
          add_result(KIND_REPLY, CMD_IAC, '0);
          add_result(KIND_REPLY, CMD_WILL, '0);
          add_result(KIND_REPLY, OPT_ECHO, '0);
        end
      end
      OP_PW_OFF: begin
        ed_password = 1'b0;
        if (!ed_echo) begin
          add_result(KIND_REPLY, CMD_IAC, '0);
          add_result(KIND_REPLY, CMD_WONT, '0);
          add_result(KIND_REPLY, OPT_ECHO, '0);
        end
      end
      default: begin
        if (ed_ga) begin
          add_result(KIND_REPLY, CMD_IAC, '0);
          add_result(KIND_REPLY, CMD_GA, '0);
        end
        if (ed_eor) begin
          add_result(KIND_REPLY, CMD_IAC, '0);
          add_result(KIND_REPLY, CMD_EOR, '0);
        end
      end
    endcase
    if (step_out.size() != 0) step_out[$].last = 1'b1;
    foreach (step_out[i]) awaited_results.push_back(step_out[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Offers one request, with an occasional gap first, and predicts it once taken.
  // The valid stays high after acceptance until the next request or a pause.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] c);
    int gap;
    gap = (src_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_request(op, c);
  endtask

  // Stops offering requests and waits until the block has nothing left to do.
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // The register is only written while the block is idle.
  task automatic write_ga_preferred(input logic value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ed_ga_pref = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  // Exactly one assignment to the ready per falling edge.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && sink_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Every result taken is compared with the oldest one awaited.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0d tdata %04h tlast %b", $time,
                 m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        fault_count++;
      end else begin
        seen_want = awaited_results.pop_front();
        if (m_axis_tuser_o !== seen_want.kind || m_axis_tdata_o[7:0] !== seen_want.data ||
            m_axis_tdata_o[13:8] !== seen_want.len || m_axis_tdata_o[15:14] !== 2'b00 ||
            m_axis_tlast_o !== seen_want.last) begin
          $display("%0t: expected kind %0d data %02h len %0d pad 0 last %b", $time,
                   seen_want.kind, seen_want.data, seen_want.len, seen_want.last);
          $display("%0t: actual   kind %0d data %02h len %0d pad %0d last %b", $time,
                   m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[13:8],
                   m_axis_tdata_o[15:14], m_axis_tlast_o);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: the run is hung if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Printable extremes, ignored bytes, the three erase codes (the last on an
  // empty line) and both orders of the CR/LF pair.
  task automatic test_line_editing();
    send_request(OP_BYTE, B_SPACE);
    send_request(OP_BYTE, B_TILDE);
    send_request(OP_BYTE, 8'd31);     // control byte, ignored
    send_request(OP_BYTE, 8'd200);    // high byte, ignored
    send_request(OP_BYTE, B_DEL);
    send_request(OP_BYTE, CMD_EC);
    send_request(OP_BYTE, B_BS);      // nothing left to erase
    send_request(OP_BYTE, 8'h41);
    send_request(OP_BYTE, B_CR);      // line of one character
    send_request(OP_BYTE, B_LF);      // completes the CR LF pair
    send_request(OP_BYTE, B_LF);      // empty line
    send_request(OP_BYTE, B_CR);      // completes the LF CR pair
  endtask

  // Echo negotiation, password mode replies, end-of-record and go-ahead after
  // a prompt, and the interrupt that disconnects the session.
  task automatic test_telnet_options();
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_DO);
    send_request(OP_BYTE, OPT_ECHO);
    send_request(OP_BYTE, 8'h68);     // echoed
    send_request(OP_PW_ON, B_ZERO);   // echo on, so no reply
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_DONT);
    send_request(OP_BYTE, OPT_ECHO);
    send_request(OP_PW_OFF, 8'hff);   // WONT ECHO
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_DO);
    send_request(OP_BYTE, OPT_EOR);
    send_request(OP_PROMPT, B_ZERO);  // IAC EOR
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_DONT);
    send_request(OP_BYTE, OPT_EOR);
    send_request(OP_PROMPT, B_ZERO);  // IAC GA, since go-ahead is preferred
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_IP);
  endtask

  // The receiver holds off while a line longer than the store allows is typed
  // with echo on, so the echoes back up and the block stalls its input. The
  // line end then reads out a full line.
  task automatic test_full_line_backpressure();
    int i;
    // A zero byte ends any command left open by earlier noise and is ignored
    // otherwise, so the echo negotiation below always takes effect.
    send_request(OP_BYTE, B_ZERO);
    send_request(OP_PW_OFF, B_ZERO);
    send_request(OP_BYTE, CMD_IAC);
    send_request(OP_BYTE, CMD_DO);
    send_request(OP_BYTE, OPT_ECHO);
    hold_request = HOLD_OFF;
    for (i = 0; i < LINE_MAX; i++) send_request(OP_BYTE, BYTE_W'($urandom_range(B_SPACE, B_TILDE)));
    send_request(OP_BYTE, B_CR);
  endtask

  // Mostly well-formed typing and telnet sequences with random content, with
  // requests between the bytes of a command, and some raw noise.
  task automatic test_random_sessions(input int n_requests);
    int sent;
    int i;
    int pick;
    int run;
    logic [BYTE_W-1:0] cmd;
    sent = 0;
    while (sent < n_requests) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run = $urandom_range(1, 8);
        for (i = 0; i < run; i++) send_request(OP_BYTE, BYTE_W'($urandom_range(B_SPACE, B_TILDE)));
        sent += run;
        case ($urandom_range(0, 3))
          0: begin
            send_request(OP_BYTE, B_CR);
            sent++;
          end
          1: begin
            send_request(OP_BYTE, B_LF);
            sent++;
          end
          2: begin
            send_request(OP_BYTE, B_CR);
            send_request(OP_BYTE, B_LF);
            sent += 2;
          end
          default: ;
        endcase
      end else if (pick < 50) begin
        case ($urandom_range(0, 2))
          0: send_request(OP_BYTE, B_BS);
          1: send_request(OP_BYTE, B_DEL);
          default: send_request(OP_BYTE, CMD_EC);
        endcase
        sent++;
      end else if (pick < 70) begin
        send_request(OP_BYTE, CMD_IAC);
        // A password or prompt request may fall inside a command sequence.
        if ($urandom_range(0, 4) == 0) begin
          send_request(OP_W'($urandom_range(OP_PW_ON, OP_PROMPT)), BYTE_W'($urandom));
          sent++;
        end
        case ($urandom_range(0, 8))
          0: cmd = CMD_EC;
          1: cmd = CMD_EL;
          2: cmd = CMD_IP;
          3, 4: cmd = CMD_DO;
          5, 6: cmd = CMD_DONT;
          7: cmd = CMD_IAC;
          default: cmd = BYTE_W'($urandom);
        endcase
        send_request(OP_BYTE, cmd);
        sent += 2;
        if (cmd == CMD_DO || cmd == CMD_DONT) begin
          case ($urandom_range(0, 3))
            0: send_request(OP_BYTE, OPT_ECHO);
            1: send_request(OP_BYTE, OPT_EOR);
            2: send_request(OP_BYTE, OPT_SGA);
            default: send_request(OP_BYTE, BYTE_W'($urandom));
          endcase
          sent++;
        end
      end else if (pick < 82) begin
        send_request(OP_W'($urandom_range(OP_PW_ON, OP_PROMPT)), BYTE_W'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_request(OP_BYTE, ($urandom_range(0, 1) == 0) ? B_CR : B_LF);
        sent++;
      end else begin
        send_request(OP_BYTE, BYTE_W'($urandom));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_BYTE;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 1'b0;
    src_idle        = 1'b1;
    sink_idle       = 1'b1;
    ed_count        = 0;
    ed_phase        = PH_DATA;
    ed_after_cr     = 1'b0;
    ed_after_lf     = 1'b0;
    ed_echo         = 1'b0;
    ed_password     = 1'b0;
    ed_eor          = 1'b0;
    ed_ga           = 1'b0;
    ed_ga_pref      = 1'b0;
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_line_editing();
    write_ga_preferred(1'b1);
    test_telnet_options();
    test_random_sessions(35);
    write_ga_preferred(1'b0);
    test_full_line_backpressure();
    test_random_sessions(20);
    write_ga_preferred(1'b1);
    // Final stretch at full rate on both sides.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    test_random_sessions(20);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
